### rtl/i2p_pkg.sv
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

  // token kinds on the request side
  typedef enum logic [2:0] {
    CMD_OPERAND = 3'd0,
    CMD_FUNC    = 3'd1,
    CMD_COMMA   = 3'd2,
    CMD_OPER    = 3'd3,
    CMD_LPAREN  = 3'd4,
    CMD_RPAREN  = 3'd5,
    CMD_END     = 3'd6
  } cmd_t;

  // operator codes
  localparam logic [2:0] OP_PLUS  = 3'd0;
  localparam logic [2:0] OP_MINUS = 3'd1;
  localparam logic [2:0] OP_TIMES = 3'd2;
  localparam logic [2:0] OP_MOD   = 3'd4;
  localparam logic [2:0] OP_POW   = 3'd5;

  // result kinds
  localparam logic [1:0] RK_OPERAND = 2'd0;
  localparam logic [1:0] RK_OPER    = 2'd1;
  localparam logic [1:0] RK_FUNC    = 2'd2;
  localparam logic [1:0] RK_STATUS  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_COMMA    = 3'd1;
  localparam logic [2:0] ST_RPAREN   = 3'd2;
  localparam logic [2:0] ST_LPAREN   = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  // stack entry kinds
  typedef enum logic [1:0] {
    EK_LPAREN = 2'd0,
    EK_FUNC   = 2'd1,
    EK_OPER   = 2'd2
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t kind;
    logic [4:0]  code;
  } entry_t;

  typedef enum logic [1:0] {
    SOP_HOLD,
    SOP_PUSH,
    SOP_POP
  } stack_op_t;

  typedef struct packed {
    stack_op_t op;
    entry_t    data;
  } stack_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_RPFN,
    S_STATUS
  } state_t;

  function automatic logic [2:0] prec(input logic [2:0] code);
    if (code <= OP_MINUS) begin
      return 3'd2;
    end else if (code <= OP_MOD) begin
      return 3'd3;
    end else if (code == OP_POW) begin
      return 3'd4;
    end else begin
      return 3'd0;
    end
  endfunction

endpackage

### rtl/i2p_in_if.sv
interface i2p_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [11:0] operand_ref;
  logic [2:0]  op_code;
  logic [4:0]  func_id;

  modport source (output valid, output cmd, output operand_ref, output op_code,
                  output func_id, input ready);
  modport sink   (input valid, input cmd, input operand_ref, input op_code,
                  input func_id, output ready);
endinterface

### rtl/i2p_out_if.sv
interface i2p_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [11:0] out_code;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output out_kind, output out_code, output status,
                  output last, input ready);
  modport sink   (input valid, input out_kind, input out_code, input status,
                  input last, output ready);
endinterface

### rtl/infix_to_postfix_converter.sv
// Streaming shunting-yard converter: takes classified infix tokens on the
// token channel and returns postfix tokens on the result channel, every
// request closing with one status item marked last. The operator stack is a
// row of 32 shift cells with the top always in the first cell, so a push or
// pop shifts every cell of the row by one place together. Each token has a
// work step and a step for its closing status item, during which the next
// token may already be taken; each stack entry it pops and emits takes a
// step of its own, and a right parenthesis passes through a further state
// that checks for a function beneath the matching left parenthesis. The
// pop walk goes one entry per cycle through the cell row while the sink
// takes results; cycles in which the result register is held by the sink
// stall it. After an error only the status item is returned until the end
// token, which reports the error and returns the block to its reset state.
module infix_to_postfix_converter (
  input  logic      clk,
  input  logic      rst,
  i2p_in_if.sink    token,
  i2p_out_if.source result
);
  import i2p_pkg::*;

  state_t     state, state_next;

  // latched request
  logic [2:0]  tok_cmd;
  logic [11:0] tok_ref;
  logic [2:0]  tok_op;
  logic [4:0]  tok_fid;
  logic        load_tok;

  // converter state
  logic [COUNT_W-1:0] count, count_next;
  logic [2:0]         prev_kind, prev_kind_next;
  logic               at_start, at_start_next;
  logic [2:0]         err, err_next;

  // result register
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [11:0] out_code;
  logic [2:0]  out_status;
  logic        out_last;

  logic        emit;
  logic [1:0]  emit_kind;
  logic [11:0] emit_code;
  logic [2:0]  emit_status;
  logic        emit_last;

  // stack control
  stack_ctl_t ctl;
  entry_t     top;
  logic       do_push;
  logic       do_pop;
  entry_t     push_data;

  logic can_emit;
  logic empty;
  logic full;
  logic unary;
  logic popit;
  logic in_ready;

  i2p_stack u_stack (
    .clk (clk),
    .ctl (ctl),
    .top (top)
  );

  assign can_emit = !out_valid || result.ready;
  assign empty    = (count == '0);
  assign full     = (count == COUNT_W'(STACK_DEPTH));
  // plus/minus in prefix position becomes uplus/uminus
  assign unary    = (tok_op == OP_PLUS || tok_op == OP_MINUS) &&
                    (at_start || prev_kind == CMD_FUNC || prev_kind == CMD_COMMA ||
                     prev_kind == CMD_OPER || prev_kind == CMD_LPAREN);
  // power is right-associative, everything else left
  assign popit    = (tok_op == OP_POW) ? (prec(tok_op) <  prec(top.code[2:0]))
                                       : (prec(tok_op) <= prec(top.code[2:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    prev_kind_next = prev_kind;
    at_start_next  = at_start;
    err_next       = err;
    in_ready       = 1'b0;
    load_tok       = 1'b0;
    emit           = 1'b0;
    emit_kind      = RK_STATUS;
    emit_code      = '0;
    emit_status    = ST_OK;
    emit_last      = 1'b0;
    do_push        = 1'b0;
    do_pop         = 1'b0;
    push_data      = '{kind: EK_LPAREN, code: '0};

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (token.valid) begin
          load_tok   = 1'b1;
          state_next = S_RUN;
        end
      end

      S_RUN: begin
        if (can_emit) begin
          if (tok_cmd == CMD_END) begin
            // drain top-down; a left paren left over is an error
            if (err == ST_OK && !empty) begin
              if (top.kind == EK_LPAREN) begin
                err_next   = ST_LPAREN;
                state_next = S_STATUS;
              end else begin
                emit   = 1'b1;
                do_pop = 1'b1;
              end
            end else begin
              state_next = S_STATUS;
            end
          end else if (err != ST_OK) begin
            state_next = S_STATUS;
          end else begin
            case (tok_cmd)
              CMD_OPERAND: begin
                emit       = 1'b1;
                emit_kind  = RK_OPERAND;
                emit_code  = tok_ref;
                state_next = S_STATUS;
              end
              CMD_FUNC: begin
                do_push    = 1'b1;
                push_data  = '{kind: EK_FUNC, code: tok_fid};
                state_next = S_STATUS;
              end
              CMD_COMMA: begin
                if (empty) begin
                  err_next   = ST_COMMA;
                  state_next = S_STATUS;
                end else if (top.kind != EK_LPAREN) begin
                  emit   = 1'b1;
                  do_pop = 1'b1;
                end else begin
                  state_next = S_STATUS;
                end
              end
              CMD_OPER: begin
                if (unary) begin
                  do_push    = 1'b1;
                  push_data  = '{kind: EK_FUNC, code: {2'b00, tok_op}};
                  state_next = S_STATUS;
                end else if (!empty && (top.kind == EK_FUNC ||
                                        (top.kind == EK_OPER && popit))) begin
                  emit   = 1'b1;
                  do_pop = 1'b1;
                end else begin
                  do_push    = 1'b1;
                  push_data  = '{kind: EK_OPER, code: {2'b00, tok_op}};
                  state_next = S_STATUS;
                end
              end
              CMD_LPAREN: begin
                do_push    = 1'b1;
                push_data  = '{kind: EK_LPAREN, code: '0};
                state_next = S_STATUS;
              end
              CMD_RPAREN: begin
                if (empty) begin
                  err_next   = ST_RPAREN;
                  state_next = S_STATUS;
                end else if (top.kind == EK_LPAREN) begin
                  do_pop     = 1'b1;
                  state_next = S_RPFN;
                end else begin
                  emit   = 1'b1;
                  do_pop = 1'b1;
                end
              end
              default: begin
                state_next = S_STATUS;
              end
            endcase
          end
        end
      end

      S_RPFN: begin
        // a function name directly before the paren group
        if (can_emit) begin
          if (!empty && top.kind == EK_FUNC) begin
            emit   = 1'b1;
            do_pop = 1'b1;
          end
          state_next = S_STATUS;
        end
      end

      S_STATUS: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_kind   = RK_STATUS;
          emit_status = err;
          emit_last   = 1'b1;
          if (tok_cmd == CMD_END) begin
            count_next     = '0;
            prev_kind_next = CMD_OPERAND;
            at_start_next  = 1'b1;
            err_next       = ST_OK;
          end else if (tok_cmd <= CMD_RPAREN) begin
            prev_kind_next = tok_cmd;
            at_start_next  = 1'b0;
          end
          in_ready = 1'b1;
          if (token.valid) begin
            load_tok   = 1'b1;
            state_next = S_RUN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // popped entries go out as operator or function tokens
    if (do_pop) begin
      emit_kind  = (top.kind == EK_OPER) ? RK_OPER : RK_FUNC;
      emit_code  = {7'd0, top.code};
      count_next = count - COUNT_W'(1);
    end

    ctl = '{op: SOP_HOLD, data: push_data};
    if (do_pop) begin
      ctl.op = SOP_POP;
    end else if (do_push) begin
      if (full) begin
        err_next = ST_OVERFLOW;
      end else begin
        ctl.op     = SOP_PUSH;
        count_next = count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      prev_kind <= CMD_OPERAND;
      at_start  <= 1'b1;
      err       <= ST_OK;
    end else begin
      count     <= count_next;
      prev_kind <= prev_kind_next;
      at_start  <= at_start_next;
      err       <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_tok) begin
      tok_cmd <= token.cmd;
      tok_ref <= token.operand_ref;
      tok_op  <= token.op_code;
      tok_fid <= token.func_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= emit_kind;
      out_code   <= emit_code;
      out_status <= emit_status;
      out_last   <= emit_last;
    end
  end

  assign token.ready     = in_ready;
  assign result.valid    = out_valid;
  assign result.out_kind = out_kind;
  assign result.out_code = out_code;
  assign result.status   = out_status;
  assign result.last     = out_last;

endmodule

### rtl/i2p_cell.sv
module i2p_cell (
  input  logic               clk,
  input  i2p_pkg::stack_op_t op,
  input  i2p_pkg::entry_t    above,
  input  i2p_pkg::entry_t    below,
  output i2p_pkg::entry_t    q
);
  import i2p_pkg::*;

  // push shifts down the row, pop shifts up
  always_ff @(posedge clk) begin
    case (op)
      SOP_PUSH: q <= above;
      SOP_POP:  q <= below;
      default:  q <= q;
    endcase
  end

endmodule

### rtl/i2p_stack.sv
module i2p_stack (
  input  logic                clk,
  input  i2p_pkg::stack_ctl_t ctl,
  output i2p_pkg::entry_t     top
);
  import i2p_pkg::*;

  entry_t ent [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t above;
    entry_t below;

    if (i == 0) begin : g_first
      assign above = ctl.data;
    end else begin : g_mid
      assign above = ent[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = ent[i];
    end else begin : g_notlast
      assign below = ent[i+1];
    end

    i2p_cell u_cell (
      .clk   (clk),
      .op    (ctl.op),
      .above (above),
      .below (below),
      .q     (ent[i])
    );
  end

  assign top = ent[0];

endmodule

### verif/infix_to_postfix_converter_chk.sv
`timescale 1ns / 100ps

module infix_to_postfix_converter_chk (
  input  logic clk,
  input  logic rst,
  i2p_in_if    token,
  i2p_out_if   result,
  output int   fail_count,
  output int   outstanding
);
  import i2p_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] code;
    logic [2:0]  status;
    logic        last;
  } postfix_item_t;

  postfix_item_t postfix_q[$];

  // shadow of the operator stack and expression state
  entry_t     opstk[STACK_DEPTH];
  int         depth;
  logic [2:0] prev_cmd;
  logic       at_start;
  logic [2:0] err;

  function automatic void clear_state();
    depth    = 0;
    prev_cmd = CMD_OPERAND;
    at_start = 1'b1;
    err      = ST_OK;
  endfunction

  function automatic void emit(logic [1:0] kind, logic [11:0] code, logic [2:0] status,
                               logic last);
    postfix_q.push_back('{kind: kind, code: code, status: status, last: last});
  endfunction

  function automatic void emit_entry(entry_t e);
    emit((e.kind == EK_OPER) ? RK_OPER : RK_FUNC, 12'(e.code), ST_OK, 1'b0);
  endfunction

  function automatic entry_t pop_entry();
    depth--;
    return opstk[depth];
  endfunction

  // a push onto a full stack is dropped and flags overflow
  function automatic void push_entry(entry_kind_t kind, logic [4:0] code);
    if (depth >= STACK_DEPTH) begin
      err = ST_OVERFLOW;
    end else begin
      opstk[depth] = '{kind: kind, code: code};
      depth++;
    end
  endfunction

  function automatic int op_rank(logic [4:0] code);
    if (code <= 5'(OP_MINUS)) begin
      return 2;
    end else if (code <= 5'(OP_MOD)) begin
      return 3;
    end else if (code == 5'(OP_POW)) begin
      return 4;
    end
    return 0;
  endfunction

  task automatic shunt_token(input logic [2:0] cmd, input logic [11:0] opnd,
                             input logic [2:0] op, input logic [4:0] fid);
    entry_t e;
    bit     found;
    bit     popit;
    found = 1'b0;
    if (cmd == CMD_END) begin
      if (err == ST_OK) begin
        while (depth > 0) begin
          e = pop_entry();
          if (e.kind == EK_LPAREN) begin
            err = ST_LPAREN;
            break;
          end
          emit_entry(e);
        end
      end
      emit(RK_STATUS, '0, err, 1'b1);
      clear_state();
      return;
    end
    if (err != ST_OK || cmd > CMD_END) begin
      emit(RK_STATUS, '0, err, 1'b1);
      return;
    end

    case (cmd)
      CMD_OPERAND: begin
        emit(RK_OPERAND, opnd, ST_OK, 1'b0);
      end
      CMD_FUNC: begin
        push_entry(EK_FUNC, fid);
      end
      CMD_COMMA: begin
        while (depth > 0 && opstk[depth - 1].kind != EK_LPAREN) begin
          emit_entry(pop_entry());
        end
        if (depth == 0) begin
          err = ST_COMMA;
        end
      end
      CMD_OPER: begin
        if (op <= OP_MINUS &&
            (at_start || (prev_cmd >= CMD_FUNC && prev_cmd <= CMD_LPAREN))) begin
          push_entry(EK_FUNC, 5'(op));
        end else begin
          while (depth > 0) begin
            e = opstk[depth - 1];
            if (e.kind == EK_FUNC) begin
              popit = 1'b1;
            end else if (e.kind == EK_OPER) begin
              popit = (op == OP_POW) ? (op_rank(5'(op)) < op_rank(e.code))
                                     : (op_rank(5'(op)) <= op_rank(e.code));
            end else begin
              popit = 1'b0;
            end
            if (!popit) begin
              break;
            end
            emit_entry(pop_entry());
          end
          push_entry(EK_OPER, 5'(op));
        end
      end
      CMD_LPAREN: begin
        push_entry(EK_LPAREN, 5'd0);
      end
      default: begin
        while (depth > 0) begin
          e = pop_entry();
          if (e.kind == EK_LPAREN) begin
            found = 1'b1;
            break;
          end
          emit_entry(e);
        end
        if (!found) begin
          err = ST_RPAREN;
        end else if (depth > 0 && opstk[depth - 1].kind == EK_FUNC) begin
          emit_entry(pop_entry());
        end
      end
    endcase

    prev_cmd = cmd;
    at_start = 1'b0;
    emit(RK_STATUS, '0, err, 1'b1);
  endtask

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    postfix_item_t want;
    if (rst) begin
      clear_state();
      postfix_q.delete();
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (result.valid && result.ready) begin
        if (postfix_q.size() == 0) begin
          fail_count++;
          $error("unexpected result: kind %0d code %0d status %0d last %0d",
                 result.out_kind, result.out_code, result.status, result.last);
        end else begin
          want = postfix_q.pop_front();
          check_field("out_kind", 12'(want.kind), 12'(result.out_kind));
          check_field("out_code", want.code, result.out_code);
          check_field("status", 12'(want.status), 12'(result.status));
          check_field("last", 12'(want.last), 12'(result.last));
        end
      end
      if (token.valid && token.ready) begin
        shunt_token(token.cmd, token.operand_ref, token.op_code, token.func_id);
      end
    end
    outstanding <= postfix_q.size();
  end

endmodule

### verif/infix_to_postfix_converter_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the shunting-yard converter. The checker beside
// the block watches both channels, predicts the postfix stream and counts
// failures; this module only produces requests, paces the result side and
// decides pass or fail.
module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 300;
  localparam int LONG_HOLD     = 300;   // result side held off, cycles
  localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 64;

  // codes the package leaves unnamed
  localparam logic [2:0] OP_DIV    = 3'd3;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [2:0] CMD_SPARE = 3'd7;
  localparam logic [4:0] FN_UPLUS  = 5'd0;
  localparam logic [4:0] FN_UMINUS = 5'd1;
  localparam logic [4:0] FN_TOP    = 5'd31;

  logic clk = 1'b0;
  logic rst = 1'b1;

  i2p_in_if  token_if ();
  i2p_out_if result_if ();

  int fail_count;
  int outstanding;

  int src_idle_pct  = 0;  // only the stimulus process reads this
  int sink_idle_pct = 0;  // written with NBAs, read by the result pacer
  int hold_req      = 0;  // bumped to ask the result pacer for a long hold
  int sent          = 0;  // requests taken, ignored codes excluded

  always #CLK_HALF clk = ~clk;

  infix_to_postfix_converter u_top (
    .clk    (clk),
    .rst    (rst),
    .token  (token_if),
    .result (result_if)
  );

  infix_to_postfix_converter_chk u_chk (
    .clk         (clk),
    .rst         (rst),
    .token       (token_if),
    .result      (result_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Offer one request and hold it until taken. Idle cycles go in front, so
  // valid drops only when a gap is really wanted: never lowered and raised
  // in the same step.
  task automatic send_token(input logic [2:0] cmd, input logic [11:0] opnd,
                            input logic [2:0] op, input logic [4:0] fid);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      token_if.valid <= 1'b0;
      @(posedge clk);
    end
    token_if.valid       <= 1'b1;
    token_if.cmd         <= cmd;
    token_if.operand_ref <= opnd;
    token_if.op_code     <= op;
    token_if.func_id     <= fid;
    @(posedge clk);
    while (!token_if.ready) begin
      @(posedge clk);
    end
    if (cmd != CMD_SPARE) begin
      sent++;
    end
  endtask

  // unused fields get random values so every bit toggles regardless
  task automatic send_operand(input logic [11:0] opnd);
    send_token(CMD_OPERAND, opnd, 3'($urandom), 5'($urandom));
  endtask

  task automatic send_oper(input logic [2:0] op);
    send_token(CMD_OPER, 12'($urandom), op, 5'($urandom));
  endtask

  task automatic send_func(input logic [4:0] fid);
    send_token(CMD_FUNC, 12'($urandom), 3'($urandom), fid);
  endtask

  task automatic send_bare(input logic [2:0] cmd);
    send_token(cmd, 12'($urandom), 3'($urandom), 5'($urandom));
  endtask

  // anything at all, spare command code and spare operators included
  task automatic send_noise();
    send_token(3'($urandom_range(0, 7)), 12'($urandom), 3'($urandom), 5'($urandom));
  endtask

  // mostly the operator codes 0 to 5, now and then a spare code
  function automatic logic [2:0] rand_op();
    if ($urandom_range(0, 19) == 0) begin
      return 3'($urandom_range(OP_SPARE6, OP_SPARE7));
    end
    return 3'($urandom_range(0, 5));
  endfunction

  // Well-formed expression of roughly len tokens with random content: a
  // small grammar walk that alternates terms and operators, opens and
  // closes brackets, uses commas inside brackets and now and then slips in
  // a noise token to break the sequence. Always closed by an end request.
  task automatic send_expression(input int len);
    int n;
    int open;
    bit want_term;
    int pick;
    n         = 0;
    open      = 0;
    want_term = 1'b1;
    while (n < len || want_term || open > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_noise();
      end else if (want_term) begin
        if (n >= len || pick < 50) begin
          send_operand(12'($urandom));
          want_term = 1'b0;
        end else if (pick < 62) begin
          send_oper(3'($urandom_range(OP_PLUS, OP_MINUS)));  // unary
        end else if (open < 6) begin
          if (pick < 80) begin
            send_func(5'($urandom));
          end
          send_bare(CMD_LPAREN);
          open++;
        end else begin
          send_operand(12'($urandom));
          want_term = 1'b0;
        end
      end else if (open > 0 && (n >= len || pick < 25)) begin
        send_bare(CMD_RPAREN);
        open--;
      end else if (open > 0 && pick < 35) begin
        send_bare(CMD_COMMA);
        want_term = 1'b1;
      end else begin
        send_oper(rand_op());
        want_term = 1'b1;
      end
      n++;
    end
    send_bare(CMD_END);
  endtask

  // drop valid and sit until the checker holds no more expectations
  task automatic wait_drained();
    token_if.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (outstanding != 0);
  endtask

  initial begin : stimulus
    int pick;
    int len;
    int levels;
    token_if.valid       <= 1'b0;
    token_if.cmd         <= CMD_OPERAND;
    token_if.operand_ref <= '0;
    token_if.op_code     <= OP_PLUS;
    token_if.func_id     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first idling mix: sender 27 %, receiver 67 %
    src_idle_pct  = 27;
    sink_idle_pct <= 67;

    // ---- directed part --------------------------------------------------

    // empty expression
    send_bare(CMD_END);

    // precedence and associativity; unary at start and after an operator;
    // every binary code but plus, including the two spare ones
    send_oper(OP_MINUS);
    send_operand(12'hFFF);
    send_oper(OP_POW);
    send_operand(12'h000);
    send_oper(OP_POW);            // right-associative: the first one stays
    send_oper(OP_PLUS);           // unary after an operator
    send_operand(12'hAAA);
    send_oper(OP_TIMES);
    send_operand(12'h555);
    send_oper(OP_DIV);
    send_operand(12'h001);
    send_oper(OP_MOD);
    send_operand(12'h800);
    send_oper(OP_MINUS);          // binary this time
    send_operand(12'h7FF);
    send_oper(OP_SPARE6);         // lowest precedence, left-associative
    send_operand(12'h0F0);
    send_oper(OP_SPARE7);
    send_operand(12'hF0F);
    send_bare(CMD_END);

    // functions, brackets and commas; unary after a left bracket, a comma
    // and a function; reserved ids from the input act as plain functions;
    // a right bracket pops the function beneath its partner
    send_func(FN_TOP);
    send_bare(CMD_LPAREN);
    send_oper(OP_MINUS);
    send_operand(12'h123);
    send_bare(CMD_COMMA);
    send_oper(OP_PLUS);
    send_func(FN_UMINUS);
    send_oper(OP_MINUS);
    send_func(FN_UPLUS);
    send_bare(CMD_LPAREN);
    send_operand(12'h321);
    send_bare(CMD_RPAREN);
    send_bare(CMD_RPAREN);
    send_bare(CMD_SPARE);         // ignored code, only its status item comes back
    send_bare(CMD_END);

    // comma outside brackets; later tokens only echo the error
    send_operand(12'h00A);
    send_bare(CMD_COMMA);
    send_operand(12'h00B);
    send_oper(OP_PLUS);
    send_bare(CMD_SPARE);
    send_bare(CMD_END);

    // right bracket without a partner, after popping the plus
    send_operand(12'h00C);
    send_oper(OP_PLUS);
    send_operand(12'h00D);
    send_bare(CMD_RPAREN);
    send_bare(CMD_END);

    // left bracket still open at the end; the drain stops on it
    send_bare(CMD_LPAREN);
    send_operand(12'h00E);
    send_oper(OP_TIMES);
    send_operand(12'h00F);
    send_bare(CMD_END);

    // one push more than the stack holds
    for (int i = 0; i < STACK_DEPTH; i++) begin
      send_func(5'(i));
    end
    send_bare(CMD_LPAREN);
    send_operand(12'h010);
    send_bare(CMD_END);

    // sender pauses until every result is back
    wait_drained();

    // ---- random part, three idling mixes --------------------------------
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 27;
          sink_idle_pct <= 67;
        end
        1: begin
          src_idle_pct  = 67;
          sink_idle_pct <= 27;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct <= 0;
          // receiver stalls for a long stretch while requests keep coming,
          // so the block backs up and stops taking input
          hold_req <= hold_req + 1;
        end
      endcase
      while (sent < (phase + 1) * RANDOM_ITEMS / 3) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          len = $urandom_range(1, 8);
          repeat (len) send_noise();
          send_bare(CMD_END);
        end else if (pick < 13) begin
          // deep nesting, overflowing for most depths
          levels = $urandom_range(12, 34);
          repeat (levels) begin
            if ($urandom_range(0, 1) == 1) begin
              send_func(5'($urandom));
            end
            send_bare(CMD_LPAREN);
          end
          send_operand(12'($urandom));
          repeat (levels) send_bare(CMD_RPAREN);
          send_bare(CMD_END);
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          send_expression(len);
        end
      end
      wait_drained();
    end

    // let any stray result show itself before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: random back-pressure, plus the long hold on request
  // ---------------------------------------------------------------------
  initial begin : result_pacer
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too long without any handshake ends the run
  // ---------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((token_if.valid && token_if.ready) || (result_if.valid && result_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
rtl/i2p_pkg.sv
rtl/i2p_in_if.sv
rtl/i2p_out_if.sv
rtl/i2p_cell.sv
rtl/i2p_stack.sv
rtl/infix_to_postfix_converter.sv
verif/infix_to_postfix_converter_chk.sv
verif/infix_to_postfix_converter_tb.sv
